FILE: sv/fdns_pkg.sv
// Shared types, byte codes and the name compare helper of the directory name search.
package fdns_pkg;

   // Input word: one directory byte and the start mark
   typedef struct packed {
      logic [7:0] dir_byte;
      logic       start_search;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic        found;
      logic [15:0] start_cluster;
      logic [15:0] entry_index;
   } rsp_word_type;

   // Target name as held in the register bank
   typedef struct packed {
      logic [63:0] chars_low;
      logic [31:0] chars_high;
      logic [3:0]  length;
   } target_type;

   // Output stage status seen by the scan stage
   typedef struct packed {
      logic skid_full;
   } out_status_type;

   // Running name compare state
   typedef struct packed {
      logic [3:0] length;
      logic       mismatch;
   } name_state_type;

   // Register bank
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 64;
   localparam logic [1:0]  REG_CHARS_LOW  = 2'd0;
   localparam logic [1:0]  REG_CHARS_HIGH = 2'd1;
   localparam logic [1:0]  REG_LENGTH     = 2'd2;

   // Directory byte codes and entry positions
   localparam logic [7:0] ENTRY_END_MARK = 8'h00;
   localparam logic [7:0] ENTRY_DELETED  = 8'hE5;
   localparam logic [7:0] ATTR_VOLUME    = 8'h08;
   localparam logic [7:0] ATTR_DIRECTORY = 8'h10;
   localparam logic [7:0] SPACE_CHAR     = 8'h20;
   localparam logic [7:0] DOT_CHAR       = 8'h2E;
   localparam logic [4:0] POS_FIRST      = 5'h00;
   localparam logic [4:0] POS_EXT_START  = 5'h08;
   localparam logic [4:0] POS_ATTR       = 5'h0B;
   localparam logic [4:0] POS_CLUSTER_LO = 5'h1A;
   localparam logic [4:0] POS_CLUSTER_HI = 5'h1B;
   localparam logic [4:0] POS_LAST       = 5'h1F;
   localparam logic [3:0] MAX_NAME_CHARS = 4'd12;
   localparam logic [3:0] LENGTH_LIMIT   = 4'd15;
   localparam logic [15:0] ENTRY_MAX     = 16'hFFFF;

   // Add one character to the built name and compare it with the target
   function automatic name_state_type append_char(name_state_type st, logic [7:0] c,
                                                  target_type tgt);
      name_state_type nx;
      logic [95:0]    chars;
      logic [3:0]     idx;
      logic [7:0]     want;
      nx    = st;
      chars = {tgt.chars_high, tgt.chars_low};
      idx   = (st.length < MAX_NAME_CHARS) ? st.length : 4'd0;
      want  = chars[{idx, 3'b000} +: 8];
      if (st.length >= MAX_NAME_CHARS || st.length >= tgt.length || want != c) begin
         nx.mismatch = 1'b1;
      end
      if (st.length < LENGTH_LIMIT) begin
         nx.length = st.length + 4'd1;
      end
      return nx;
   endfunction

endpackage

FILE: sv/fdns_csr.sv
// Register bank holding the target file name, written and read over the APB-style port.
module fdns_csr import fdns_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output target_type            target
);

   target_type target_ff;
   logic       write_en;
   logic [1:0] reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite;
   assign reg_index = paddr[CSR_ADDR_W-1:3];
   assign target    = target_ff;

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (write_en) begin
         case (reg_index)
            REG_CHARS_LOW:  target_ff.chars_low  <= pwdata;
            REG_CHARS_HIGH: target_ff.chars_high <= pwdata[31:0];
            REG_LENGTH:     target_ff.length     <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      case (reg_index)
         REG_CHARS_LOW:  prdata = target_ff.chars_low;
         REG_CHARS_HIGH: prdata = {32'd0, target_ff.chars_high};
         REG_LENGTH:     prdata = {60'd0, target_ff.length};
         default:        prdata = '0;
      endcase
   end

endmodule

FILE: sv/fdns_scan.sv
// Input register, entry scan state and the single-pass name match logic.
module fdns_scan import fdns_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  target_type     target,
   input  logic           req_valid,
   input  req_word_type   req_word,
   output logic           in_stall,
   input  out_status_type out_status,
   output logic           res_valid,
   output rsp_word_type   res_word
);

   logic           in_valid_ff, in_valid_in;
   req_word_type   in_word_ff;
   logic           advance;

   logic [4:0]     pos_ff, pos_in;
   logic [15:0]    cnt_ff, cnt_in;
   logic           done_ff, done_in;
   name_state_type name_ff, name_in;
   logic           stop_ff, stop_in;
   logic           skip_ff, skip_in;
   logic [7:0]     clo_ff, clo_in;

   // Advance the held word once the output side has room for a result
   assign advance  = in_valid_ff && !out_status.skid_full;
   assign in_stall = in_valid_ff && out_status.skid_full;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !in_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Work out the next scan state and any result for the held byte
   always_comb begin
      logic [7:0] b;
      logic       hit;
      b      = in_word_ff.dir_byte;
      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      name_in = name_ff;
      stop_in = stop_ff;
      skip_in = skip_ff;
      clo_in  = clo_ff;
      hit      = 1'b0;
      res_word = '0;

      // Start mark: clear all progress
      if (in_word_ff.start_search) begin
         pos_in  = '0;
         cnt_in  = '0;
         done_in = 1'b0;
         name_in = '0;
         stop_in = 1'b0;
         skip_in = 1'b0;
         clo_in  = '0;
      end

      if (!done_in) begin
         if (pos_in == POS_FIRST && b == ENTRY_END_MARK) begin
            // End of directory: report not found
            hit                  = 1'b1;
            res_word.found       = 1'b0;
            res_word.entry_index = cnt_in;
            done_in              = 1'b1;
         end else begin
            if (pos_in == POS_FIRST && b == ENTRY_DELETED) begin
               skip_in = 1'b1;
            end
            // Dot between name and extension
            if (pos_in == POS_EXT_START) begin
               name_in = append_char(name_in, DOT_CHAR, target);
               stop_in = 1'b0;
            end
            if (pos_in < POS_ATTR) begin
               if (!stop_in) begin
                  if (b == SPACE_CHAR) begin
                     stop_in = 1'b1;
                  end else begin
                     name_in = append_char(name_in, b, target);
                  end
               end
            end else if (pos_in == POS_ATTR) begin
               if ((b & (ATTR_VOLUME | ATTR_DIRECTORY)) != 8'h00) begin
                  skip_in = 1'b1;
               end
            end else if (pos_in == POS_CLUSTER_LO) begin
               clo_in = b;
            end else if (pos_in == POS_CLUSTER_HI) begin
               if (!skip_in && !name_in.mismatch && name_in.length == target.length) begin
                  hit                    = 1'b1;
                  res_word.found         = 1'b1;
                  res_word.start_cluster = {b, clo_in};
                  res_word.entry_index   = cnt_in;
                  done_in                = 1'b1;
               end
            end
            // Close the entry and step to the next byte
            if (!done_in) begin
               if (pos_in == POS_LAST) begin
                  if (cnt_in != ENTRY_MAX) begin
                     cnt_in = cnt_in + 16'd1;
                  end
                  name_in = '0;
                  stop_in = 1'b0;
                  skip_in = 1'b0;
                  clo_in  = '0;
               end
               pos_in = pos_in + 5'd1;
            end
         end
      end
      res_valid = advance && hit;
   end

   // Hold the input word
   always_ff @(posedge clock) begin
      if (req_valid && !in_stall) begin
         in_word_ff <= req_word;
      end
   end

   // Hold the scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= '0;
         cnt_ff      <= '0;
         done_ff     <= 1'b1;
         name_ff     <= '0;
         stop_ff     <= 1'b0;
         skip_ff     <= 1'b0;
         clo_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            pos_ff  <= pos_in;
            cnt_ff  <= cnt_in;
            done_ff <= done_in;
            name_ff <= name_in;
            stop_ff <= stop_in;
            skip_ff <= skip_in;
            clo_ff  <= clo_in;
         end
      end
   end

endmodule

FILE: sv/fdns_out.sv
// Result register with a one-word skid stage towards the result channel.
module fdns_out import fdns_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           res_valid,
   input  rsp_word_type   res_word,
   output logic           rsp_valid,
   output rsp_word_type   rsp_word,
   input  logic           rsp_stall,
   output out_status_type out_status
);

   logic         out_valid_ff;
   rsp_word_type out_word_ff;
   logic         skid_valid_ff;
   rsp_word_type skid_word_ff;
   logic         free;

   assign free                 = !out_valid_ff || !rsp_stall;
   assign rsp_valid            = out_valid_ff;
   assign rsp_word             = out_word_ff;
   assign out_status.skid_full = skid_valid_ff;

   // Load the output register from the skid word first, else from the new result
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= res_valid;
         end
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Move the payload words
   always_ff @(posedge clock) begin
      if (free) begin
         out_word_ff <= skid_valid_ff ? skid_word_ff : res_word;
      end else if (res_valid) begin
         skid_word_ff <= res_word;
      end
   end

endmodule

FILE: sv/fat_dir_entry_name_search_top.sv
// Top level of the FAT directory 8.3 name search.
//
// Feed the root directory one byte per req_ word, entry after entry, with
// start_search high on byte 0 of entry 0. The target name (characters and
// length, dot included) is written over the APB-style port beforehand,
// while the block is idle.
// A search gives one rsp_ word: found with the start cluster and entry index
// on byte 0x1B of the matching entry, or not found on byte 0 of an entry
// whose first byte is 0x00. Later bytes are ignored until the next start.
// The byte that ends the search passes the input register and the match
// logic; the result word is registered. One byte per cycle is taken while
// req_stall is low; the scan state is updated in one pass.
// When the receiver stalls, the result waits in the output register and a
// skid word keeps input flowing; req_stall rises only once both are full.
// Reset clears the register bank and the scan state; the block then ignores
// bytes until one carries start_search.
module fat_dir_entry_name_search_top import fdns_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  req_word_type          req_word,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output rsp_word_type          rsp_word,
   input  logic                  rsp_stall,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   target_type     target;
   out_status_type out_status;
   logic           res_valid;
   rsp_word_type   res_word;

   fdns_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .target  (target)
   );

   fdns_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .target     (target),
      .req_valid  (req_valid),
      .req_word   (req_word),
      .in_stall   (req_stall),
      .out_status (out_status),
      .res_valid  (res_valid),
      .res_word   (res_word)
   );

   fdns_out u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_word   (res_word),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word),
      .rsp_stall  (rsp_stall),
      .out_status (out_status)
   );

`ifndef SYNTHESIS
   // A skid word only exists behind a waiting output word
   assert property (@(posedge clock) disable iff (reset)
      out_status.skid_full |-> rsp_valid)
      else $error("skid word held with empty output register");

   // The skid word drains as soon as the receiver takes the output word
   assert property (@(posedge clock) disable iff (reset)
      out_status.skid_full && !rsp_stall |=> !out_status.skid_full)
      else $error("skid word not drained");

   // No new result while the skid word is occupied
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !out_status.skid_full)
      else $error("result produced with no room");
`endif

endmodule
